// ----- rtl/core/prle24_pkg.sv -----
// Shared types and constants of the planar RLE24 run decoder.
package prle24_pkg;

	localparam int MAX_PIXELS = 16384;
	localparam int PIX_W = $clog2(MAX_PIXELS + 1);
	localparam int POS_W = 14;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 15;
	localparam int SKIP_W = 4;
	localparam int CH_W = 2;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SKIP = 1'd1;

	localparam logic [PIX_W-1:0] PIXEL_COUNT_RST = PIX_W'(MAX_PIXELS);
	localparam logic [SKIP_W-1:0] LEAD_SKIP_RST = 4'd4;

	localparam logic [BYTE_W-1:0] CTRL_REPEAT_MIN = 8'h80;
	localparam logic [BYTE_W-1:0] REPEAT_BIAS = 8'd125;
	localparam logic [CH_W-1:0] LAST_PLANE = 2'd2;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_SKIP,
		PH_CTRL,
		PH_LIT,
		PH_REP,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data_byte;
		logic              frame_start;
	} in_stage_t;

	typedef struct packed {
		logic advance;
		logic load;
	} step_ctl_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [POS_W-1:0]  start_pixel;
		logic [BYTE_W-1:0] run_length;
		logic [BYTE_W-1:0] sample_value;
		logic              plane_end;
		logic              image_end;
		logic              overrun;
	} run_t;

endpackage

// ----- rtl/core/planar_rle24_run_decoder_top.sv -----
// Top level of the planar RLE24 run decoder.
//
//   Channel   Direction  Payload
//   s_axis    in         one compressed byte, frame start flag
//   m_axis    out        one run: plane, start pixel, length, value, end and overrun flags
//   cfg       in         register index and write data
//
// Each byte passes an input register, then the decoder logic, then the result
// register, from which its run is offered. One byte is taken every cycle while
// results drain; a full result register stalls only bytes that make a run.
// Reset clears the control state and loads the register defaults: 16384 pixels
// per plane and four lead bytes.
module planar_rle24_run_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0: data_byte[7:0].
	input  logic [prle24_pkg::BYTE_W-1:0]     s_axis_tdata,
	// Fields from bit 0: frame_start.
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0: start_pixel[13:0], run_length[21:14], sample_value[29:22].
	output logic [prle24_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// Fields from bit 0: channel[1:0], plane_end[2], overrun[3].
	output logic [prle24_pkg::OUT_USER_W-1:0] m_axis_tuser,
	// The run completes the blue plane (image_end).
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [prle24_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prle24_pkg::CFG_DATA_W-1:0] cfg_data
);
	import prle24_pkg::*;

	in_stage_t stage;
	step_ctl_t ctl;
	run_t      run;
	logic      slot_free;

	prle24_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ctl           (ctl),
		.stage         (stage)
	);

	prle24_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stage     (stage),
		.slot_free (slot_free),
		.ctl       (ctl),
		.run       (run)
	);

	prle24_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.run           (run),
		.slot_free     (slot_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- rtl/core/prle24_in_reg.sv -----
// Input register stage holding one compressed byte until the decoder takes it.
module prle24_in_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [prle24_pkg::BYTE_W-1:0] s_axis_tdata,
	input  logic                          s_axis_tuser,
	input  prle24_pkg::step_ctl_t         ctl,
	output prle24_pkg::in_stage_t         stage
);
	import prle24_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              fs_s1;
	logic              take;

	assign s_axis_tready = !valid_s1 || ctl.advance;
	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (ctl.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= s_axis_tdata;
			fs_s1 <= s_axis_tuser;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data_byte = data_s1;
	assign stage.frame_start = fs_s1;

endmodule

// ----- rtl/core/prle24_decode.sv -----
// Decoder state, configuration registers and run computation for one byte.
module prle24_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [prle24_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prle24_pkg::CFG_DATA_W-1:0] cfg_data,
	input  prle24_pkg::in_stage_t             stage,
	input  logic                              slot_free,
	output prle24_pkg::step_ctl_t             ctl,
	output prle24_pkg::run_t                  run
);
	import prle24_pkg::*;

	logic [PIX_W-1:0]  pixel_count_q;
	logic [SKIP_W-1:0] lead_skip_q;

	phase_t            phase_q, phase_d;
	logic [SKIP_W-1:0] skip_q, skip_d;
	logic [CH_W-1:0]   plane_q, plane_d;
	logic [PIX_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] lit_q, lit_d;
	logic [BYTE_W-1:0] rep_q, rep_d;

	logic [PIX_W-1:0]  cnt;
	logic [PIX_W-1:0]  avail;
	logic [BYTE_W-1:0] req;
	logic              over_req;
	logic [BYTE_W-1:0] len;
	logic [PIX_W-1:0]  pos_sum;
	logic              pend;
	logic [BYTE_W-1:0] lit_dec;
	logic              is_lit;
	logic              produces;
	logic [SKIP_W-1:0] skip_dec;
	logic [SKIP_W-1:0] lead_dec;
	logic              byte_is_rep;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= PIXEL_COUNT_RST;
			lead_skip_q <= LEAD_SKIP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PIXEL_COUNT: pixel_count_q <= cfg_data[PIX_W-1:0];
				CFG_LEAD_SKIP:   lead_skip_q <= cfg_data[SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective plane size, with zero acting as one and a cap at the maximum.
	always_comb begin
		if (pixel_count_q == '0) begin
			cnt = PIX_W'(1);
		end else if (pixel_count_q > PIX_W'(MAX_PIXELS)) begin
			cnt = PIX_W'(MAX_PIXELS);
		end else begin
			cnt = pixel_count_q;
		end
	end

	assign is_lit = (phase_q == PH_LIT);
	assign lit_dec = lit_q - 8'd1;
	assign skip_dec = skip_q - 4'd1;
	assign lead_dec = lead_skip_q - 4'd1;
	assign byte_is_rep = (stage.data_byte >= CTRL_REPEAT_MIN);
	assign req = is_lit ? 8'd1 : rep_q;
	assign avail = (pos_q < cnt) ? (cnt - pos_q) : '0;
	assign over_req = {{(PIX_W-BYTE_W){1'b0}}, req} > avail;
	assign len = over_req ? avail[BYTE_W-1:0] : req;
	assign pos_sum = pos_q + {{(PIX_W-BYTE_W){1'b0}}, len};
	assign pend = (pos_sum >= cnt);

	assign produces = !stage.frame_start && (phase_q == PH_LIT || phase_q == PH_REP);
	assign ctl.advance = stage.valid && (slot_free || !produces);
	assign ctl.load = ctl.advance && produces;

	always_comb begin
		run.channel = plane_q;
		run.start_pixel = pos_q[POS_W-1:0];
		run.run_length = len;
		run.sample_value = stage.data_byte;
		run.plane_end = pend;
		run.image_end = pend && (plane_q >= LAST_PLANE);
		run.overrun = over_req || (pend && is_lit && (lit_dec != '0));
	end

	always_comb begin
		phase_d = phase_q;
		skip_d = skip_q;
		plane_d = plane_q;
		pos_d = pos_q;
		lit_d = lit_q;
		rep_d = rep_q;
		if (stage.frame_start) begin
			plane_d = '0;
			pos_d = '0;
			lit_d = '0;
			rep_d = '0;
			if (lead_skip_q != '0) begin
				skip_d = lead_dec;
				phase_d = (lead_dec != '0) ? PH_SKIP : PH_CTRL;
			end else begin
				skip_d = '0;
				if (byte_is_rep) begin
					rep_d = stage.data_byte - REPEAT_BIAS;
					phase_d = PH_REP;
				end else begin
					lit_d = stage.data_byte + 8'd1;
					phase_d = PH_LIT;
				end
			end
		end else begin
			unique case (phase_q)
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = PH_CTRL;
					end
				end
				PH_CTRL: begin
					if (byte_is_rep) begin
						rep_d = stage.data_byte - REPEAT_BIAS;
						phase_d = PH_REP;
					end else begin
						lit_d = stage.data_byte + 8'd1;
						phase_d = PH_LIT;
					end
				end
				PH_LIT, PH_REP: begin
					if (is_lit) begin
						lit_d = lit_dec;
						phase_d = (lit_dec != '0) ? PH_LIT : PH_CTRL;
					end else begin
						phase_d = PH_CTRL;
					end
					if (pend) begin
						pos_d = '0;
						if (plane_q >= LAST_PLANE) begin
							phase_d = PH_DONE;
						end else begin
							plane_d = plane_q + 2'd1;
							if (is_lit && lit_dec != '0) begin
								phase_d = PH_DRAIN;
							end
						end
					end else begin
						pos_d = pos_sum;
					end
				end
				PH_DRAIN: begin
					lit_d = lit_dec;
					if (lit_dec == '0) begin
						phase_d = PH_CTRL;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			skip_q <= '0;
			plane_q <= '0;
			pos_q <= '0;
			lit_q <= '0;
			rep_q <= '0;
		end else if (ctl.advance) begin
			phase_q <= phase_d;
			skip_q <= skip_d;
			plane_q <= plane_d;
			pos_q <= pos_d;
			lit_q <= lit_d;
			rep_q <= rep_d;
		end
	end

endmodule

// ----- rtl/core/prle24_out_reg.sv -----
// Result register that holds one run until the downstream side takes it.
module prle24_out_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  prle24_pkg::step_ctl_t             ctl,
	input  prle24_pkg::run_t                  run,
	output logic                              slot_free,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [prle24_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [prle24_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                              m_axis_tlast
);
	import prle24_pkg::*;

	logic valid_s2;
	run_t run_s2;

	assign slot_free = !valid_s2 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.load) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			run_s2 <= run;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {{(OUT_DATA_W-POS_W-2*BYTE_W){1'b0}},
		run_s2.sample_value, run_s2.run_length, run_s2.start_pixel};
	assign m_axis_tuser = {run_s2.overrun, run_s2.plane_end, run_s2.channel};
	assign m_axis_tlast = run_s2.image_end;

endmodule
